// File: rtl/core/sfs_pkg.sv
// Shared types and constants of the sensor frame serializer.
package sfs_pkg;

    localparam int unsigned FrameOverhead = 14;
    localparam int unsigned MaxFrame      = 20;
    localparam int unsigned PayloadStart  = 7;

    localparam int unsigned PosWidth  = $clog2(MaxFrame + 1);
    localparam int unsigned CfgWidth  = 16;

    localparam logic [15:0] HeaderWordReset      = 16'hAA55;
    localparam logic [15:0] TailWordReset        = 16'h55AA;
    localparam logic [7:0]  TypeSensorDataReset  = 8'd1;
    localparam logic [7:0]  TypeStatusReset      = 8'd2;
    localparam logic [7:0]  TypeHeartbeatReset   = 8'd3;
    localparam logic [7:0]  DigitalKindReset     = 8'd0;
    localparam logic [7:0]  QualityGoodReset     = 8'd0;
    localparam logic [7:0]  SizeLimitReset       = 8'd255;

    typedef enum logic [2:0] {
        CfgHeaderWord     = 3'd0,
        CfgTailWord       = 3'd1,
        CfgTypeSensorData = 3'd2,
        CfgTypeStatus     = 3'd3,
        CfgTypeHeartbeat  = 3'd4,
        CfgDigitalKind    = 3'd5,
        CfgQualityGood    = 3'd6,
        CfgSizeLimit      = 3'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        OpDigital   = 2'd0,
        OpStatus    = 2'd1,
        OpHeartbeat = 2'd2,
        OpUnused    = 2'd3
    } opcode_t;

    typedef struct packed {
        logic [15:0] header_word;
        logic [15:0] tail_word;
        logic [7:0]  type_sensor_data;
        logic [7:0]  type_status;
        logic [7:0]  type_heartbeat;
        logic [7:0]  digital_kind_code;
        logic [7:0]  quality_good_code;
        logic [7:0]  size_limit;
    } cfg_t;

    // One classified frame request, as the back end needs it.
    typedef struct packed {
        logic        rejected;
        logic [15:0] sensor_tag;
        logic [7:0]  type_code;
        logic [2:0]  payload_len;
        logic [47:0] payload;
        logic [31:0] timestamp;
    } desc_t;

endpackage

// File: rtl/core/sfs_front.sv
// Front end: classifies one request into a frame descriptor.
module sfs_front (
    input  logic [1:0]    opcode,
    input  logic [15:0]   sensor_tag,
    input  logic          detected,
    input  logic [7:0]    status_code,
    input  logic [31:0]   uptime_seconds,
    input  logic [7:0]    battery_charge,
    input  logic [31:0]   timestamp,
    input  sfs_pkg::cfg_t cfg,
    output logic          desc_ok,
    output sfs_pkg::desc_t desc
);

    logic [sfs_pkg::PosWidth-1:0] frame_size;

    always_comb
    begin
        desc_ok          = 1'b1;
        desc.sensor_tag  = sensor_tag;
        desc.timestamp   = timestamp;
        desc.type_code   = cfg.type_sensor_data;
        desc.payload_len = 3'd6;
        desc.payload     = {cfg.digital_kind_code, 24'd0, 7'd0, detected,
                            cfg.quality_good_code};
        case (sfs_pkg::opcode_t'(opcode))
            sfs_pkg::OpDigital:
            begin
            end
            sfs_pkg::OpStatus:
            begin
                desc.type_code   = cfg.type_status;
                desc.payload_len = 3'd1;
                desc.payload     = {status_code, 40'd0};
            end
            sfs_pkg::OpHeartbeat:
            begin
                desc.type_code   = cfg.type_heartbeat;
                desc.payload_len = 3'd5;
                desc.payload     = {uptime_seconds, battery_charge, 8'd0};
            end
            default:
            begin
                desc_ok = 1'b0;
            end
        endcase
        frame_size    = sfs_pkg::PosWidth'(sfs_pkg::FrameOverhead)
                      + sfs_pkg::PosWidth'(desc.payload_len);
        desc.rejected = (8'(frame_size) > cfg.size_limit);
    end

endmodule

// File: rtl/core/sfs_desc_fifo.sv
// Short descriptor queue between the front end and the back end.
module sfs_desc_fifo #(
    parameter int unsigned DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  sfs_pkg::desc_t wr_data,
    input  logic           rd_en,
    output sfs_pkg::desc_t rd_data,
    output logic           full,
    output logic           empty
);

    localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntWidth = $clog2(DEPTH + 1);

    sfs_pkg::desc_t mem [DEPTH];

    logic [PtrWidth-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrWidth-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntWidth-1:0] count_reg, count_next;
    logic                do_wr, do_rd;

    assign full    = (count_reg == CntWidth'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: rtl/core/sfs_back.sv
// Back end: walks one descriptor byte by byte into the output register.
module sfs_back (
    input  logic           clk,
    input  logic           rst_n,
    input  sfs_pkg::cfg_t  cfg,
    input  sfs_pkg::desc_t head,
    input  logic           head_valid,
    output logic           head_pop,
    input  logic           pop,
    output logic           empty,
    output logic [7:0]     frame_byte,
    output logic           last_byte,
    output logic           rejected
);

    localparam int unsigned PW = sfs_pkg::PosWidth;

    logic [PW-1:0] pos_reg, pos_next;
    logic [7:0]    xor_reg, xor_next;
    logic          valid_reg, valid_next;
    logic [7:0]    byte_reg;
    logic          last_reg;
    logic          rej_reg;

    logic [PW-1:0] frame_size;
    logic [PW-1:0] pay_end;
    logic [PW-1:0] ts_end;
    logic [2:0]    pay_idx;
    logic [1:0]    ts_idx;
    logic [7:0]    cur_byte;
    logic          cur_last;
    logic          cur_in_sum;
    logic          emit;

    assign emit     = head_valid && (!valid_reg || pop);
    assign head_pop = emit && cur_last;

    always_comb
    begin
        frame_size = PW'(sfs_pkg::FrameOverhead) + PW'(head.payload_len);
        pay_end    = PW'(sfs_pkg::PayloadStart) + PW'(head.payload_len);
        ts_end     = pay_end + PW'(4);
        pay_idx    = 3'(pos_reg - PW'(sfs_pkg::PayloadStart));
        ts_idx     = 2'(pos_reg - pay_end);
        cur_last   = 1'b0;
        cur_in_sum = (pos_reg >= PW'(2)) && (pos_reg < frame_size - PW'(3));
        cur_byte   = 8'd0;
        if (head.rejected)
        begin
            cur_last   = 1'b1;
            cur_in_sum = 1'b0;
        end
        else if (pos_reg == PW'(0))
        begin
            cur_byte = cfg.header_word[15:8];
        end
        else if (pos_reg == PW'(1))
        begin
            cur_byte = cfg.header_word[7:0];
        end
        else if (pos_reg == PW'(2))
        begin
            cur_byte = head.sensor_tag[15:8];
        end
        else if (pos_reg == PW'(3))
        begin
            cur_byte = head.sensor_tag[7:0];
        end
        else if (pos_reg == PW'(4))
        begin
            cur_byte = head.type_code;
        end
        else if (pos_reg == PW'(5))
        begin
            cur_byte = 8'd0;
        end
        else if (pos_reg == PW'(6))
        begin
            cur_byte = {5'd0, head.payload_len};
        end
        else if (pos_reg < pay_end)
        begin
            case (pay_idx)
                3'd0:    cur_byte = head.payload[47:40];
                3'd1:    cur_byte = head.payload[39:32];
                3'd2:    cur_byte = head.payload[31:24];
                3'd3:    cur_byte = head.payload[23:16];
                3'd4:    cur_byte = head.payload[15:8];
                3'd5:    cur_byte = head.payload[7:0];
                default: cur_byte = 8'd0;
            endcase
        end
        else if (pos_reg < ts_end)
        begin
            case (ts_idx)
                2'd0:    cur_byte = head.timestamp[31:24];
                2'd1:    cur_byte = head.timestamp[23:16];
                2'd2:    cur_byte = head.timestamp[15:8];
                default: cur_byte = head.timestamp[7:0];
            endcase
        end
        else if (pos_reg == ts_end)
        begin
            cur_byte = xor_reg;
        end
        else if (pos_reg == ts_end + PW'(1))
        begin
            cur_byte = cfg.tail_word[15:8];
        end
        else
        begin
            cur_byte = cfg.tail_word[7:0];
            cur_last = 1'b1;
        end
    end

    always_comb
    begin
        pos_next   = pos_reg;
        xor_next   = xor_reg;
        valid_next = valid_reg;
        if (emit)
        begin
            valid_next = 1'b1;
            if (cur_last)
            begin
                pos_next = '0;
                xor_next = 8'd0;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
                if (cur_in_sum)
                begin
                    xor_next = xor_reg ^ cur_byte;
                end
            end
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            xor_reg   <= 8'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            xor_reg   <= xor_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            byte_reg <= cur_byte;
            last_reg <= cur_last;
            rej_reg  <= head.rejected;
        end
    end

    assign empty      = !valid_reg;
    assign frame_byte = byte_reg;
    assign last_byte  = last_reg;
    assign rejected   = rej_reg;

`ifndef SYNTHESIS
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < PW'(sfs_pkg::MaxFrame))
        else $error("byte position ran past the longest frame");

    a_pos_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg != '0) |-> head_valid)
        else $error("frame in progress without a descriptor at the queue head");

    a_pop_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        head_pop |=> (pos_reg == '0) && (xor_reg == 8'd0))
        else $error("position or checksum not cleared after a frame");

    a_reject_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && rej_reg) |-> last_reg)
        else $error("rejection result not marked as last");
`endif

endmodule

// File: rtl/core/sensor_frame_serializer_unit.sv
// Top level of the sensor frame serializer: configuration registers and datapath wiring.
//
// Usage:
// The input side is a queue write port: a request transaction (opcode, sensor id,
// reading fields, timestamp) is taken at a clock edge with push high and full low.
// The result side is a queue read port: while empty is low, frame_byte, last_byte
// and rejected show the oldest result, and a pop with empty low takes it.
// Each request produces one frame, one byte per result transaction: 20 bytes for
// a digital reading, 15 for a status and 19 for a heartbeat, with last_byte set on
// the final tail byte. A frame longer than size_limit yields a single result with
// frame_byte zero and both last_byte and rejected set. Opcode 3 is taken and dropped.
// The front end classifies a request in the accept cycle and writes it into a
// descriptor queue (DESC_DEPTH entries); the back end then emits one byte per
// cycle while the receiver keeps popping, passing each byte through the output
// register to the result ports, with no gap between frames. The queue keeps taking
// requests while the back end is still sending an earlier frame.
// When the receiver stalls, the output register holds its byte, the back end
// waits, and full rises once the queue has filled. Reset empties the queue and
// output and returns every configuration register to its default value.
module sensor_frame_serializer_unit #(
    parameter int unsigned DESC_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        push,
    output logic        full,
    input  logic [1:0]  opcode,
    input  logic [15:0] sensor_tag,
    input  logic        detected,
    input  logic [7:0]  status_code,
    input  logic [31:0] uptime_seconds,
    input  logic [7:0]  battery_charge,
    input  logic [31:0] timestamp,

    output logic        empty,
    input  logic        pop,
    output logic [7:0]  frame_byte,
    output logic        last_byte,
    output logic        rejected,

    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [sfs_pkg::CfgWidth-1:0] cfg_data
);

    sfs_pkg::cfg_t  cfg_reg, cfg_next;
    sfs_pkg::desc_t front_desc;
    sfs_pkg::desc_t head_desc;
    logic           front_ok;
    logic           fifo_empty;
    logic           head_pop;

    // Configuration registers. The user must write them only while the block is idle;
    // the block does not enforce this, and both ends read them directly.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (sfs_pkg::cfg_index_t'(cfg_index))
                sfs_pkg::CfgHeaderWord:     cfg_next.header_word       = cfg_data[15:0];
                sfs_pkg::CfgTailWord:       cfg_next.tail_word         = cfg_data[15:0];
                sfs_pkg::CfgTypeSensorData: cfg_next.type_sensor_data  = cfg_data[7:0];
                sfs_pkg::CfgTypeStatus:     cfg_next.type_status       = cfg_data[7:0];
                sfs_pkg::CfgTypeHeartbeat:  cfg_next.type_heartbeat    = cfg_data[7:0];
                sfs_pkg::CfgDigitalKind:    cfg_next.digital_kind_code = cfg_data[7:0];
                sfs_pkg::CfgQualityGood:    cfg_next.quality_good_code = cfg_data[7:0];
                sfs_pkg::CfgSizeLimit:      cfg_next.size_limit        = cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_word       <= sfs_pkg::HeaderWordReset;
            cfg_reg.tail_word         <= sfs_pkg::TailWordReset;
            cfg_reg.type_sensor_data  <= sfs_pkg::TypeSensorDataReset;
            cfg_reg.type_status       <= sfs_pkg::TypeStatusReset;
            cfg_reg.type_heartbeat    <= sfs_pkg::TypeHeartbeatReset;
            cfg_reg.digital_kind_code <= sfs_pkg::DigitalKindReset;
            cfg_reg.quality_good_code <= sfs_pkg::QualityGoodReset;
            cfg_reg.size_limit        <= sfs_pkg::SizeLimitReset;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: classification of the incoming request.
    sfs_front u_front (
        .opcode         (opcode),
        .sensor_tag     (sensor_tag),
        .detected       (detected),
        .status_code    (status_code),
        .uptime_seconds (uptime_seconds),
        .battery_charge (battery_charge),
        .timestamp      (timestamp),
        .cfg            (cfg_reg),
        .desc_ok        (front_ok),
        .desc           (front_desc)
    );

    // Descriptor queue; an unused opcode is accepted but never enqueued.
    sfs_desc_fifo #(
        .DEPTH (DESC_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push && front_ok),
        .wr_data (front_desc),
        .rd_en   (head_pop),
        .rd_data (head_desc),
        .full    (full),
        .empty   (fifo_empty)
    );

    // Back end: byte sequencer, checksum and output register.
    sfs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head       (head_desc),
        .head_valid (!fifo_empty),
        .head_pop   (head_pop),
        .pop        (pop),
        .empty      (empty),
        .frame_byte (frame_byte),
        .last_byte  (last_byte),
        .rejected   (rejected)
    );

endmodule

// File: dv/sfs_frame_checker.sv
// Checker of the sensor frame serializer: predicts every frame byte and compares the results.
module sfs_frame_checker (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        push,
    input  logic        full,
    input  logic [1:0]  opcode,
    input  logic [15:0] sensor_tag,
    input  logic        detected,
    input  logic [7:0]  status_code,
    input  logic [31:0] uptime_seconds,
    input  logic [7:0]  battery_charge,
    input  logic [31:0] timestamp,

    input  logic        empty,
    input  logic        pop,
    input  logic [7:0]  frame_byte,
    input  logic        last_byte,
    input  logic        rejected,

    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [sfs_pkg::CfgWidth-1:0] cfg_data,

    output int          mismatches,
    output int          bytes_due
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       rej;
    } frame_beat_t;

    sfs_pkg::cfg_t cfg;
    frame_beat_t   frame_bytes_due[$];
    frame_beat_t   due;

    task automatic flag_mismatch(input string what);
        $display("%0t: mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Builds the whole frame a request asks for and queues its bytes in send order.
    task automatic predict_frame(input sfs_pkg::opcode_t op, input logic [15:0] sid,
                                 input logic det, input logic [7:0] stat,
                                 input logic [31:0] upt, input logic [7:0] batt,
                                 input logic [31:0] ts);
        logic [7:0]  payload [6];
        logic [7:0]  frame [sfs_pkg::MaxFrame];
        logic [7:0]  type_code;
        logic [7:0]  csum;
        int unsigned plen;
        int unsigned n;
        int unsigned k;
        case (op)
            sfs_pkg::OpDigital:
            begin
                payload[0] = cfg.digital_kind_code;
                payload[1] = 8'h00;
                payload[2] = 8'h00;
                payload[3] = 8'h00;
                payload[4] = {7'b0, det};
                payload[5] = cfg.quality_good_code;
                plen       = 6;
                type_code  = cfg.type_sensor_data;
            end
            sfs_pkg::OpStatus:
            begin
                payload[0] = stat;
                plen       = 1;
                type_code  = cfg.type_status;
            end
            sfs_pkg::OpHeartbeat:
            begin
                payload[0] = upt[31:24];
                payload[1] = upt[23:16];
                payload[2] = upt[15:8];
                payload[3] = upt[7:0];
                payload[4] = batt;
                plen       = 5;
                type_code  = cfg.type_heartbeat;
            end
            default:
            begin
                return;
            end
        endcase

        if (sfs_pkg::FrameOverhead + plen > cfg.size_limit)
        begin
            frame_bytes_due.push_back(frame_beat_t'{8'h00, 1'b1, 1'b1});
            return;
        end

        frame[0] = cfg.header_word[15:8];
        frame[1] = cfg.header_word[7:0];
        frame[2] = sid[15:8];
        frame[3] = sid[7:0];
        frame[4] = type_code;
        frame[5] = 8'h00;
        frame[6] = plen[7:0];
        for (k = 0; k < plen; k++)
            frame[sfs_pkg::PayloadStart + k] = payload[k];
        n = sfs_pkg::PayloadStart + plen;
        for (k = 0; k < 4; k++)
            frame[n + k] = ts[8 * (3 - k) +: 8];
        n = n + 4;
        csum = 8'h00;
        for (k = 2; k < n; k++)
            csum ^= frame[k];
        frame[n]     = csum;
        frame[n + 1] = cfg.tail_word[15:8];
        frame[n + 2] = cfg.tail_word[7:0];
        n = n + 3;
        for (k = 0; k < n; k++)
            frame_bytes_due.push_back(frame_beat_t'{frame[k], k == n - 1, 1'b0});
    endtask

    initial
    begin
        mismatches = 0;
        bytes_due  = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg = '{header_word:       sfs_pkg::HeaderWordReset,
                   tail_word:         sfs_pkg::TailWordReset,
                   type_sensor_data:  sfs_pkg::TypeSensorDataReset,
                   type_status:       sfs_pkg::TypeStatusReset,
                   type_heartbeat:    sfs_pkg::TypeHeartbeatReset,
                   digital_kind_code: sfs_pkg::DigitalKindReset,
                   quality_good_code: sfs_pkg::QualityGoodReset,
                   size_limit:        sfs_pkg::SizeLimitReset};
            frame_bytes_due.delete();
        end
        else
        begin
            if (pop && !empty)
            begin
                if (frame_bytes_due.size() == 0)
                    flag_mismatch($sformatf("result byte %02h with nothing due", frame_byte));
                else
                begin
                    due = frame_bytes_due.pop_front();
                    if (frame_byte !== due.data)
                        flag_mismatch($sformatf("frame_byte %02h, expected %02h",
                                                frame_byte, due.data));
                    if (last_byte !== due.last)
                        flag_mismatch($sformatf("last_byte %b, expected %b",
                                                last_byte, due.last));
                    if (rejected !== due.rej)
                        flag_mismatch($sformatf("rejected %b, expected %b",
                                                rejected, due.rej));
                end
            end

            // A request taken at this edge still sees the register values from
            // before a write at the same edge, as the block does.
            if (push && !full)
                predict_frame(sfs_pkg::opcode_t'(opcode), sensor_tag, detected, status_code,
                              uptime_seconds, battery_charge, timestamp);

            if (cfg_write)
            begin
                case (sfs_pkg::cfg_index_t'(cfg_index))
                    sfs_pkg::CfgHeaderWord:     cfg.header_word       = cfg_data[15:0];
                    sfs_pkg::CfgTailWord:       cfg.tail_word         = cfg_data[15:0];
                    sfs_pkg::CfgTypeSensorData: cfg.type_sensor_data  = cfg_data[7:0];
                    sfs_pkg::CfgTypeStatus:     cfg.type_status       = cfg_data[7:0];
                    sfs_pkg::CfgTypeHeartbeat:  cfg.type_heartbeat    = cfg_data[7:0];
                    sfs_pkg::CfgDigitalKind:    cfg.digital_kind_code = cfg_data[7:0];
                    sfs_pkg::CfgQualityGood:    cfg.quality_good_code = cfg_data[7:0];
                    sfs_pkg::CfgSizeLimit:      cfg.size_limit        = cfg_data[7:0];
                    default:                    ;
                endcase
            end
        end
        bytes_due = frame_bytes_due.size();
    end

endmodule

// File: dv/tb_top.sv
// Top of the sensor frame serializer testbench: clock, reset, stimulus and verdict.
module tb_top;

    // One frame request as the sender drives it onto the input ports.
    typedef struct {
        sfs_pkg::opcode_t op;
        logic [15:0]      sid;
        logic             det;
        logic [7:0]       stat;
        logic [31:0]      upt;
        logic [7:0]       batt;
        logic [31:0]      ts;
    } frame_request_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [1:0]  opcode;
    logic [15:0] sensor_tag;
    logic        detected;
    logic [7:0]  status_code;
    logic [31:0] uptime_seconds;
    logic [7:0]  battery_charge;
    logic [31:0] timestamp;
    logic        empty;
    logic        pop;
    logic [7:0]  frame_byte;
    logic        last_byte;
    logic        rejected;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [sfs_pkg::CfgWidth-1:0] cfg_data;

    int mismatches;
    int bytes_due;

    // The receiver process picks up a long hold-off when this is raised and clears it
    // once the hold-off is over. The quiet flag turns all random idling off for the
    // final part of the run.
    bit hold_off_request;
    bit quiet_tail;

    sensor_frame_serializer_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .opcode         (opcode),
        .sensor_tag     (sensor_tag),
        .detected       (detected),
        .status_code    (status_code),
        .uptime_seconds (uptime_seconds),
        .battery_charge (battery_charge),
        .timestamp      (timestamp),
        .empty          (empty),
        .pop            (pop),
        .frame_byte     (frame_byte),
        .last_byte      (last_byte),
        .rejected       (rejected),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    sfs_frame_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .opcode         (opcode),
        .sensor_tag     (sensor_tag),
        .detected       (detected),
        .status_code    (status_code),
        .uptime_seconds (uptime_seconds),
        .battery_charge (battery_charge),
        .timestamp      (timestamp),
        .empty          (empty),
        .pop            (pop),
        .frame_byte     (frame_byte),
        .last_byte      (last_byte),
        .rejected       (rejected),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .bytes_due      (bytes_due)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Watchdog: the slowest correct run stays well within this limit even with every
    // byte waiting out the longest receiver stall and every request the longest sender
    // gap, so the limit leaves a wide margin.
    initial
    begin
        #5000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // All inputs change on the falling edge, away from the rising edge at which
    // the block and the checker sample them.

    // Writes one configuration register. The write enable is high across exactly one
    // rising edge.
    task automatic write_reg(input sfs_pkg::cfg_index_t idx, input logic [15:0] value);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    // Loads a whole register set, one write per register.
    task automatic apply_config(input sfs_pkg::cfg_t c);
        write_reg(sfs_pkg::CfgHeaderWord,     c.header_word);
        write_reg(sfs_pkg::CfgTailWord,       c.tail_word);
        write_reg(sfs_pkg::CfgTypeSensorData, {8'h00, c.type_sensor_data});
        write_reg(sfs_pkg::CfgTypeStatus,     {8'h00, c.type_status});
        write_reg(sfs_pkg::CfgTypeHeartbeat,  {8'h00, c.type_heartbeat});
        write_reg(sfs_pkg::CfgDigitalKind,    {8'h00, c.digital_kind_code});
        write_reg(sfs_pkg::CfgQualityGood,    {8'h00, c.quality_good_code});
        write_reg(sfs_pkg::CfgSizeLimit,      {8'h00, c.size_limit});
    endtask

    // Offers one request and returns right after the edge that took it. Push stays
    // high on return, so back-to-back requests keep the input busy with no bubble.
    // Before offering, the sender may sit idle for a random burst of cycles.
    task automatic send_request(input frame_request_t r);
        @(negedge clk);
        if (!quiet_tail && $urandom_range(0, 5) == 0)
        begin
            push = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        push           = 1'b1;
        opcode         = r.op;
        sensor_tag     = r.sid;
        detected       = r.det;
        status_code    = r.stat;
        uptime_seconds = r.upt;
        battery_charge = r.batt;
        timestamp      = r.ts;
        do
            @(posedge clk);
        while (full);
    endtask

    // Waits until every predicted byte has come out, then lets the block settle
    // before the registers are touched. Opcode 3 requests make no result; they are
    // dropped at the input and never enter the descriptor queue.
    task automatic drain_block();
        @(negedge clk);
        push = 1'b0;
        while (bytes_due != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // A request whose fields are all zeros or all ones, for the directed part.
    function automatic frame_request_t uniform_request(input sfs_pkg::opcode_t op,
                                                       input logic fill);
        frame_request_t r;
        r.op   = op;
        r.sid  = {16{fill}};
        r.det  = fill;
        r.stat = {8{fill}};
        r.upt  = {32{fill}};
        r.batt = {8{fill}};
        r.ts   = {32{fill}};
        return r;
    endfunction

    // A random request. About one in twenty uses the unused opcode, which the block
    // drops; the rest are well-formed frame requests with random content.
    function automatic frame_request_t random_request();
        frame_request_t r;
        if ($urandom_range(0, 19) == 0)
            r.op = sfs_pkg::OpUnused;
        else
            r.op = sfs_pkg::opcode_t'($urandom_range(0, 2));
        r.sid  = 16'($urandom_range(0, 16'hFFFF));
        r.det  = 1'($urandom_range(0, 1));
        r.stat = 8'($urandom_range(0, 8'hFF));
        r.upt  = $urandom;
        r.batt = 8'($urandom_range(0, 8'hFF));
        r.ts   = $urandom;
        return r;
    endfunction

    // A random register set. The size limit is drawn from the values around the three
    // frame lengths often enough that rejections of each kind keep showing up.
    function automatic sfs_pkg::cfg_t random_config();
        sfs_pkg::cfg_t c;
        c.header_word       = 16'($urandom_range(0, 16'hFFFF));
        c.tail_word         = 16'($urandom_range(0, 16'hFFFF));
        c.type_sensor_data  = 8'($urandom_range(0, 8'hFF));
        c.type_status       = 8'($urandom_range(0, 8'hFF));
        c.type_heartbeat    = 8'($urandom_range(0, 8'hFF));
        c.digital_kind_code = 8'($urandom_range(0, 8'hFF));
        c.quality_good_code = 8'($urandom_range(0, 8'hFF));
        case ($urandom_range(0, 5))
            0:       c.size_limit = 8'($urandom_range(0, 14));
            1:       c.size_limit = 8'($urandom_range(15, 18));
            2:       c.size_limit = 8'd19;
            default: c.size_limit = 8'($urandom_range(20, 255));
        endcase
        return c;
    endfunction

    // Receiver. It pops whenever it is not idling; idling comes in random bursts, and
    // once the long hold-off is requested it keeps pop low for a hold-off counted here,
    // so that the descriptor queue fills and full rises while the sender keeps
    // offering requests.
    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_request)
            begin
                pop = 1'b0;
                repeat (300) @(negedge clk);
                hold_off_request = 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 6) == 0)
            begin
                pop = 1'b0;
                repeat ($urandom_range(1, 11) - 1) @(negedge clk);
            end
            else
                pop = 1'b1;
        end
    end

    // Main stimulus and verdict.
    initial
    begin
        sfs_pkg::cfg_t c;
        int            phase;

        rst_n            = 1'b0;
        push             = 1'b0;
        opcode           = sfs_pkg::OpDigital;
        sensor_tag       = '0;
        detected         = 1'b0;
        status_code      = '0;
        uptime_seconds   = '0;
        battery_charge   = '0;
        timestamp        = '0;
        cfg_write        = 1'b0;
        cfg_index        = sfs_pkg::CfgHeaderWord;
        cfg_data         = '0;
        hold_off_request = 1'b0;
        quiet_tail       = 1'b0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, with the registers at their reset values first: every
        // opcode with all fields zero and all fields one, which covers both readings
        // of a digital frame, and one dropped request with the unused opcode.
        send_request(uniform_request(sfs_pkg::OpDigital, 1'b0));
        send_request(uniform_request(sfs_pkg::OpDigital, 1'b1));
        send_request(uniform_request(sfs_pkg::OpStatus, 1'b0));
        send_request(uniform_request(sfs_pkg::OpStatus, 1'b1));
        send_request(uniform_request(sfs_pkg::OpUnused, 1'b1));
        send_request(uniform_request(sfs_pkg::OpHeartbeat, 1'b0));
        send_request(uniform_request(sfs_pkg::OpHeartbeat, 1'b1));
        drain_block();

        // Every register at zero: a size limit of zero rejects every frame.
        c = '0;
        apply_config(c);
        send_request(uniform_request(sfs_pkg::OpDigital, 1'b1));
        send_request(uniform_request(sfs_pkg::OpStatus, 1'b1));
        send_request(uniform_request(sfs_pkg::OpHeartbeat, 1'b1));
        drain_block();

        // Every marker and code at all ones. A limit of 15 lets only the status frame
        // through, 19 also the heartbeat, 20 the digital reading as well.
        c = '1;
        c.size_limit = 8'd15;
        apply_config(c);
        send_request(uniform_request(sfs_pkg::OpDigital, 1'b0));
        send_request(uniform_request(sfs_pkg::OpStatus, 1'b0));
        send_request(uniform_request(sfs_pkg::OpHeartbeat, 1'b0));
        drain_block();

        write_reg(sfs_pkg::CfgSizeLimit, 16'd19);
        send_request(uniform_request(sfs_pkg::OpDigital, 1'b1));
        send_request(uniform_request(sfs_pkg::OpStatus, 1'b1));
        send_request(uniform_request(sfs_pkg::OpHeartbeat, 1'b1));
        drain_block();

        write_reg(sfs_pkg::CfgSizeLimit, 16'd20);
        send_request(uniform_request(sfs_pkg::OpDigital, 1'b1));
        send_request(uniform_request(sfs_pkg::OpStatus, 1'b0));
        send_request(uniform_request(sfs_pkg::OpHeartbeat, 1'b1));
        drain_block();

        // Random part: seven phases of 64 requests, each under a fresh random register
        // set. The third phase carries the long receiver hold-off, and the last one
        // runs with no idling on either side and the widest size limit.
        for (phase = 0; phase < 7; phase++)
        begin
            c = random_config();
            if (phase == 6)
            begin
                c.size_limit = 8'd255;
                quiet_tail   = 1'b1;
            end
            apply_config(c);
            if (phase == 2)
                hold_off_request = 1'b1;
            repeat (64) send_request(random_request());
            drain_block();
        end

        // The final drain above has already waited for the last byte and for the
        // block to settle; a further wait catches any stray result.
        repeat (20) @(negedge clk);

        if (mismatches == 0 && bytes_due == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
